// ===== src/sled_pkg.sv =====
// ----------------------------------------------------------------------------
// sled_pkg: shared types and constants
// result kinds, decoder modes and the result record passed down the pipe
// ----------------------------------------------------------------------------
package sled_pkg;

  localparam int MAX_LEN = 4096;
  localparam int LEN_W   = 13;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_END      = 2'd1,
    KIND_EOF_ESC  = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'b001,
    MODE_ESCAPE = 3'b010,
    MODE_OCTAL  = 3'b100
  } mode_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         byte_out;
    logic [LEN_W-1:0]   length;
    logic               last;
  } res_t;

  // up to two results per character
  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } dec_out_t;

endpackage

// ===== src/sled_decode.sv =====
// ----------------------------------------------------------------------------
// sled_decode: escape decoder state and per-character logic
// turns one registered character into zero, one or two result records
// ----------------------------------------------------------------------------
module sled_decode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [7:0]          char_in,
  input  logic                end_of_input,
  output sled_pkg::dec_out_t  dec
);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  sled_pkg::mode_t                 mode_r, mode_nxt;
  logic [7:0]                      acc_r, acc_nxt;
  logic [sled_pkg::LEN_W-1:0]      cnt_r, cnt_nxt;

  function automatic logic [7:0] esc_map(input logic [7:0] c);
    logic [7:0] b;
    case (c)
      8'h6E:   b = 8'h0A;  // n
      8'h74:   b = 8'h09;  // t
      8'h72:   b = 8'h0D;  // r
      8'h64:   b = 8'h04;  // d
      8'h4E:   b = 8'h00;  // N
      8'h73:   b = 8'h20;  // s
      default: b = c;
    endcase
    return b;
  endfunction

  // true when one more byte would reach the length limit
  function automatic logic full_at(input logic [sled_pkg::LEN_W-1:0] n);
    return (32'(n) + 32'd1) >= 32'(sled_pkg::MAX_LEN);
  endfunction

  function automatic sled_pkg::res_t mk(input sled_pkg::kind_t k, input logic [7:0] b,
                                        input logic [sled_pkg::LEN_W-1:0] len,
                                        input logic lst);
    sled_pkg::res_t r;
    r.kind     = k;
    r.byte_out = b;
    r.length   = len;
    r.last     = lst;
    return r;
  endfunction

  logic                        is_digit;
  logic [sled_pkg::LEN_W-1:0]  cnt_p1;
  logic [sled_pkg::LEN_W-1:0]  cnt_p2;
  logic                        do_clear;

  assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
  assign cnt_p1   = cnt_r + 1'b1;
  assign cnt_p2   = cnt_r + 2'd2;

  always_comb begin
    dec      = '0;
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    do_clear = 1'b0;
    if (fire) begin
      case (mode_r)
        sled_pkg::MODE_ESCAPE: begin
          if (end_of_input) begin
            dec.r0   = mk(sled_pkg::KIND_EOF_ESC, 8'h00, cnt_r, 1'b1);
            dec.num  = 2'd1;
            do_clear = 1'b1;
          end else if (char_in == CH_ZERO) begin
            mode_nxt = sled_pkg::MODE_OCTAL;
            acc_nxt  = 8'h00;
          end else begin
            mode_nxt = sled_pkg::MODE_NORMAL;
            dec.num  = 2'd1;
            if (full_at(cnt_r)) begin
              dec.r0   = mk(sled_pkg::KIND_OVERFLOW, 8'h00, cnt_r, 1'b1);
              do_clear = 1'b1;
            end else begin
              dec.r0  = mk(sled_pkg::KIND_BYTE, esc_map(char_in), cnt_p1, 1'b0);
              cnt_nxt = cnt_p1;
            end
          end
        end
        sled_pkg::MODE_OCTAL: begin
          if (end_of_input) begin
            dec.r0   = mk(sled_pkg::KIND_EOF_ESC, 8'h00, cnt_r, 1'b1);
            dec.num  = 2'd1;
            do_clear = 1'b1;
          end else if (is_digit) begin
            acc_nxt = {acc_r[4:0], 3'b000} + (char_in - CH_ZERO);
          end else if (full_at(cnt_r)) begin
            dec.r0   = mk(sled_pkg::KIND_OVERFLOW, 8'h00, cnt_r, 1'b1);
            dec.num  = 2'd1;
            do_clear = 1'b1;
          end else begin
            // run value first, then the terminator as a normal character
            dec.r0   = mk(sled_pkg::KIND_BYTE, acc_r, cnt_p1, 1'b0);
            mode_nxt = sled_pkg::MODE_NORMAL;
            acc_nxt  = 8'h00;
            cnt_nxt  = cnt_p1;
            if (char_in == CH_QUOTE) begin
              dec.r1   = mk(sled_pkg::KIND_END, 8'h00, cnt_p1, 1'b1);
              dec.num  = 2'd2;
              do_clear = 1'b1;
            end else if (char_in == CH_BSLASH) begin
              mode_nxt = sled_pkg::MODE_ESCAPE;
              dec.num  = 2'd1;
            end else if (full_at(cnt_p1)) begin
              dec.r1   = mk(sled_pkg::KIND_OVERFLOW, 8'h00, cnt_p1, 1'b1);
              dec.num  = 2'd2;
              do_clear = 1'b1;
            end else begin
              dec.r1  = mk(sled_pkg::KIND_BYTE, char_in, cnt_p2, 1'b0);
              dec.num = 2'd2;
              cnt_nxt = cnt_p2;
            end
          end
        end
        default: begin
          if (end_of_input || (char_in == CH_QUOTE)) begin
            dec.r0   = mk(sled_pkg::KIND_END, 8'h00, cnt_r, 1'b1);
            dec.num  = 2'd1;
            do_clear = 1'b1;
          end else if (char_in == CH_BSLASH) begin
            mode_nxt = sled_pkg::MODE_ESCAPE;
          end else begin
            dec.num = 2'd1;
            if (full_at(cnt_r)) begin
              dec.r0   = mk(sled_pkg::KIND_OVERFLOW, 8'h00, cnt_r, 1'b1);
              do_clear = 1'b1;
            end else begin
              dec.r0  = mk(sled_pkg::KIND_BYTE, char_in, cnt_p1, 1'b0);
              cnt_nxt = cnt_p1;
            end
          end
        end
      endcase
      if (do_clear) begin
        mode_nxt = sled_pkg::MODE_NORMAL;
        acc_nxt  = 8'h00;
        cnt_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sled_pkg::MODE_NORMAL;
      acc_r  <= 8'h00;
      cnt_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // a terminating result leaves the decoder ready for a fresh literal
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && ((dec.num != 2'd0 && dec.r0.last) || (dec.num == 2'd2 && dec.r1.last))
    |=> (mode_r == sled_pkg::MODE_NORMAL) && (cnt_r == '0) && (acc_r == 8'h00))
    else $error("state not cleared after terminating result");

  // byte count never reaches the length limit
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) < 32'(sled_pkg::MAX_LEN))
    else $error("byte count out of range");

endmodule

// ===== src/sled_queue.sv =====
// ----------------------------------------------------------------------------
// sled_queue: result queue
// small register queue, up to two writes and one read per cycle
// ----------------------------------------------------------------------------
module sled_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  sled_pkg::dec_out_t  dec,
  output logic                space_ok,
  output logic                out_valid,
  input  logic                out_ready,
  output sled_pkg::res_t      out_res
);

  sled_pkg::res_t                q_r [sled_pkg::QDEPTH];
  logic [sled_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [sled_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [sled_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                          pop;
  logic [sled_pkg::QPTR_W-1:0]   wr_ptr_p1;

  assign out_valid = (cnt_r != '0);
  assign out_res   = q_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign space_ok  = (32'(cnt_r) + 32'd2) <= 32'(sled_pkg::QDEPTH);
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + sled_pkg::QPTR_W'(dec.num);
    rd_ptr_nxt = rd_ptr_r + sled_pkg::QPTR_W'(pop);
    cnt_nxt    = cnt_r + sled_pkg::QCNT_W'(dec.num) - sled_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (dec.num != 2'd0) begin
      q_r[wr_ptr_r] <= dec.r0;
    end
    if (dec.num == 2'd2) begin
      q_r[wr_ptr_p1] <= dec.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // writes only land when the space check allowed them
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (dec.num != 2'd0) |-> $past(space_ok) || (32'(cnt_r) + 32'(dec.num) <= 32'(sled_pkg::QDEPTH)))
    else $error("result queue overrun");

endmodule

// ===== src/string_literal_escape_decoder.sv =====
// ----------------------------------------------------------------------------
// string_literal_escape_decoder: quoted string body decoder
// decodes backslash escapes and octal runs, reports end of string and errors
// ----------------------------------------------------------------------------
//
//   channel  ports                                      direction  per beat
//   -------  -----------------------------------------  ---------  --------------
//   in       in_valid in_ready in_char_in               sink       one character
//            in_end_of_input
//   out      out_valid out_ready out_kind out_byte_out  source     one result
//            out_length out_last
//
// - one character per cycle sustained while the output side keeps up; a character
//   that ends an octal run makes two results, each a separate beat on the output port
// - the input register comes first, then decode into the result queue
// - synchronous active-low reset empties the input register and the queue
//   and puts the decoder in normal mode with zero length
// - the input register holds while the queue has fewer than two free slots,
//   so a stalled output side back-pressures in_ready without losing results
//
module string_literal_escape_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_char_in,
  input  logic                          in_end_of_input,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_kind,
  output logic [7:0]                    out_byte_out,
  output logic [sled_pkg::LEN_W-1:0]    out_length,
  output logic                          out_last
);

  // input register stage
  logic               in_v_r, in_v_nxt;
  logic [7:0]         in_char_r;
  logic               in_eoi_r;

  logic               space_ok;
  logic               fire;
  sled_pkg::dec_out_t dec;
  sled_pkg::res_t     out_res;

  // registered character is decoded once the queue can take two results
  assign fire     = in_v_r && space_ok;
  assign in_ready = !in_v_r || fire;
  assign in_v_nxt = (in_valid && in_ready) || (in_v_r && !fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_char_r <= in_char_in;
      in_eoi_r  <= in_end_of_input;
    end
  end

  // per-character decode and string state
  sled_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .char_in      (in_char_r),
    .end_of_input (in_eoi_r),
    .dec          (dec)
  );

  // result queue decouples two-result beats from the output handshake
  sled_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .dec       (dec),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_kind     = out_res.kind;
  assign out_byte_out = out_res.byte_out;
  assign out_length   = out_res.length;
  assign out_last     = out_res.last;

endmodule
